// File: rtl/ring_line_buffer_defines.svh
// Assertion macros shared by the ring line buffer RTL.
`ifndef RING_LINE_BUFFER_DEFINES_SVH
`define RING_LINE_BUFFER_DEFINES_SVH

// Same-cycle implication, checked on clk outside of reset.
`define RLB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk outside of reset.
`define RLB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/rlb_pkg.sv
// Shared types and constants for the ring line buffer.
`timescale 1ns / 1ps

package rlb_pkg;

  localparam int unsigned BUFFER_SIZE_DEFAULT = 64;

  // Line terminator byte
  localparam logic [7:0] NEWLINE = 8'h0A;

  // Command codes of an input item
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_ACK     = 2'd0,
    KIND_LINE    = 2'd1,
    KIND_NO_LINE = 2'd2
  } kind_t;

endpackage

// File: rtl/ring_line_buffer.sv
// Byte ring buffer with all-or-nothing write chunks and whole-line reads.
`timescale 1ns / 1ps
`include "ring_line_buffer_defines.svh"
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_ready  | cmd, data, chunk_start, chunk_len
//  out     | out_valid / out_ready| kind, accepted, line_byte, last, free_slots,
//          |                      | empty_res, full_res, line_ready
//
// A write item or a read with no stored line yields one result. A line read first
// fetches the oldest newline position from the position memory, then the first byte,
// then one byte per cycle from the data memory while the out channel is not stalled.
// Results wait in an output register; a stalled out channel freezes the byte stream.
// Reset clears the state, pointers, counters and out_valid only; the memories need no
// clearing pass.

module ring_line_buffer
  import rlb_pkg::*;
#(
  parameter int unsigned BUFFER_SIZE = BUFFER_SIZE_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       cmd,
  input  logic [7:0] data,
  input  logic       chunk_start,
  input  logic [7:0] chunk_len,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] kind,
  output logic       accepted,
  output logic [7:0] line_byte,
  output logic       last,
  output logic [5:0] free_slots,
  output logic       empty_res,
  output logic       full_res,
  output logic       line_ready
);

  localparam int unsigned IW = $clog2(BUFFER_SIZE);
  localparam logic [IW-1:0] MAX_FREE = IW'(BUFFER_SIZE - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOCATE,
    ST_STREAM
  } state_t;

  function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] i);
    return (i == MAX_FREE) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IW-1:0] used_of(input logic [IW-1:0] w, input logic [IW-1:0] r);
    logic [IW:0] diff;
    if (w >= r) diff = {1'b0, w} - {1'b0, r};
    else        diff = {1'b0, w} + (IW+1)'(BUFFER_SIZE) - {1'b0, r};
    return diff[IW-1:0];
  endfunction

  state_t        state;
  logic [IW-1:0] read_index;
  logic [IW-1:0] write_index;
  logic [IW-1:0] newline_count;
  logic [IW-1:0] chunk_remaining;
  logic          chunk_ok;
  logic [IW-1:0] nl_head;
  logic [IW-1:0] nl_tail;
  logic [IW-1:0] cur;
  logic [IW-1:0] end_idx;
  logic [IW-1:0] st_free;
  logic          st_empty;
  logic          st_line;

  logic [7:0]    ring_store [BUFFER_SIZE];
  logic [IW-1:0] nl_pos     [BUFFER_SIZE];
  logic [7:0]    rdata;
  logic [IW-1:0] pos_q;
  logic [IW-1:0] raddr;

  logic          slot_free;
  logic          acc_in;
  logic          out_load;
  logic [IW-1:0] used_now;
  logic [IW-1:0] free_now;
  logic          ok_next;
  logic [IW-1:0] rem_start;
  logic [IW-1:0] rem_next;
  logic          store;
  logic          store_nl;
  logic [IW-1:0] w_free;
  logic [IW-1:0] nlc_write;
  logic [IW-1:0] ri_after;
  logic [IW-1:0] l_used;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE) && slot_free;
  assign acc_in    = in_valid && in_ready;

  // Load a new result into the output register this cycle
  assign out_load = ((state == ST_IDLE) && acc_in &&
                     (cmd == CMD_WRITE || newline_count == '0)) ||
                    ((state == ST_STREAM) && slot_free);

  assign used_now = used_of(write_index, read_index);
  assign free_now = MAX_FREE - used_now;

  // Decide the chunk and whether this write byte is stored
  always_comb begin
    ok_next   = chunk_ok;
    rem_start = chunk_remaining;
    if (chunk_start) begin
      if (chunk_len <= 8'(free_now)) begin
        ok_next   = 1'b1;
        rem_start = chunk_len[IW-1:0];
      end else begin
        ok_next   = 1'b0;
        rem_start = '0;
      end
    end
    store     = ok_next && (rem_start != '0) && (free_now != '0);
    store_nl  = store && (data == NEWLINE);
    rem_next  = store ? rem_start - 1'b1 : rem_start;
    w_free    = store ? free_now - 1'b1 : free_now;
    nlc_write = store_nl ? newline_count + 1'b1 : newline_count;
  end

  // Status after a line read, from the oldest newline position
  assign ri_after = next_idx(pos_q);
  assign l_used   = used_of(write_index, ri_after);

  // Pick the data memory read address; hold it while the out channel stalls
  always_comb begin
    raddr = cur;
    if (state == ST_LOCATE) begin
      raddr = read_index;
    end else if (state == ST_STREAM && slot_free && cur != end_idx) begin
      raddr = next_idx(cur);
    end
  end

  // Data memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (acc_in && cmd == CMD_WRITE && store) begin
      ring_store[write_index] <= data;
    end
    rdata <= ring_store[raddr];
  end

  // Newline position memory: queue of stored newline indices
  always_ff @(posedge clk) begin
    if (acc_in && cmd == CMD_WRITE && store_nl) begin
      nl_pos[nl_tail] <= write_index;
    end
    pos_q <= nl_pos[nl_head];
  end

  // Sequencer, buffer state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      read_index      <= '0;
      write_index     <= '0;
      newline_count   <= '0;
      chunk_remaining <= '0;
      chunk_ok        <= 1'b0;
      nl_head         <= '0;
      nl_tail         <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (acc_in) begin
            if (cmd == CMD_WRITE) begin
              chunk_ok        <= ok_next;
              chunk_remaining <= rem_next;
              newline_count   <= nlc_write;
              if (store) begin
                write_index <= next_idx(write_index);
              end
              if (store_nl) begin
                nl_tail <= next_idx(nl_tail);
              end
              out_valid  <= 1'b1;
              kind       <= KIND_ACK;
              accepted   <= store;
              line_byte  <= '0;
              last       <= 1'b1;
              free_slots <= 6'(w_free);
              empty_res  <= (used_now == '0) && !store;
              full_res   <= (w_free == '0);
              line_ready <= (nlc_write != '0);
            end else if (newline_count == '0) begin
              out_valid  <= 1'b1;
              kind       <= KIND_NO_LINE;
              accepted   <= 1'b0;
              line_byte  <= '0;
              last       <= 1'b1;
              free_slots <= 6'(free_now);
              empty_res  <= (used_now == '0);
              full_res   <= (free_now == '0);
              line_ready <= 1'b0;
            end else begin
              state <= ST_LOCATE;
            end
          end
        end
        ST_LOCATE: begin
          // Commit the consumed line now; stream from the old read index
          cur           <= read_index;
          end_idx       <= pos_q;
          read_index    <= ri_after;
          newline_count <= newline_count - 1'b1;
          nl_head       <= next_idx(nl_head);
          st_free       <= MAX_FREE - l_used;
          st_empty      <= (l_used == '0);
          st_line       <= (newline_count != IW'(1));
          state         <= ST_STREAM;
        end
        ST_STREAM: begin
          if (slot_free) begin
            out_valid  <= 1'b1;
            kind       <= KIND_LINE;
            accepted   <= 1'b0;
            line_byte  <= rdata;
            last       <= (cur == end_idx);
            free_slots <= 6'(st_free);
            empty_res  <= st_empty;
            full_res   <= (st_free == '0);
            line_ready <= st_line;
            if (cur == end_idx) begin
              state <= ST_IDLE;
            end else begin
              cur <= next_idx(cur);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A line read starts only with a newline on record
  `RLB_ASSERT_NOW(a_locate_has_line, state == ST_LOCATE, newline_count != '0,
                  "line read with no newline stored")
  // The closing byte of a line is the newline itself
  `RLB_ASSERT_NOW(a_line_ends_nl, out_valid && kind == KIND_LINE && last,
                  line_byte == NEWLINE, "line closed on a non-newline byte")
  // Taking a non-final line byte brings the next one at once
  `RLB_ASSERT_NEXT(a_stream_continues, out_valid && out_ready && !last,
                   out_valid && kind == KIND_LINE, "line byte stream broke")

endmodule
